// ===== design/audio_fade_envelope_defines.svh =====
// Assertion macros for the fade envelope.
// Each macro expects clk and arst_n in scope at the place of use.
`ifndef AUDIO_FADE_ENVELOPE_DEFINES_SVH
`define AUDIO_FADE_ENVELOPE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define AFE_ASSERT_NOW(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("fade envelope check failed");
// next-cycle implication
`define AFE_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("fade envelope check failed");
`else
`define AFE_ASSERT_NOW(lbl, ant, con)
`define AFE_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

// ===== design/afe_pkg.sv =====
package afe_pkg;

	// envelope phases
	localparam logic [1:0] PH_FADE_IN  = 2'd0;
	localparam logic [1:0] PH_HOLD     = 2'd1;
	localparam logic [1:0] PH_FADE_OUT = 2'd2;
	localparam logic [1:0] PH_DONE     = 2'd3;

	// release event points
	localparam logic [1:0] NP_FADE_IN_END    = 2'd1;
	localparam logic [1:0] NP_FADE_OUT_START = 2'd2;
	localparam logic [1:0] NP_DONE           = 2'd3;

	// item kinds
	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_FORCE = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_APPEAR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISAPPEAR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FO_START  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NOTIFY    = 3'd5;

	// divider: one quotient bit per step
	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

// ===== design/audio_fade_envelope.sv =====
// Linear fade-in / hold / fade-out volume envelope for one sound.
// Input stream: s_axis_tuser carries the item kind (0 time tick, 1 force
// phase), s_axis_tdata the tick time, play position, stop flag and phase.
// Output stream: one transaction per input transaction with the gain, the
// phase after the step, the release event and the remove request.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while no transaction is in flight.
// A tick that continues a fade runs a multiply state and then a 16-step
// restoring divider (one quotient bit per cycle) before its result is
// registered; all other items go from evaluation straight to the output.
// The block takes one item at a time: s_axis_tready is high only while idle,
// and it rises in the cycle in which the result appears in the output
// register, so no new item is taken before the last result is registered.
// A stalled receiver holds the result in the output register; the next
// item is still accepted and runs, then waits for that register to free.
// Reset: phase fade-in, timer and gain 0, registers at their defaults,
// output empty.
`include "audio_fade_envelope_defines.svh"

module audio_fade_envelope (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // elapsed[15:0], play_position[47:16],
	                                   // player_stopped[48], new_phase[50:49]
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // volume[15:0], phase[17:16],
	                                   // release_event[18], remove_request[19]
	input  logic        cfg_we,
	input  logic [afe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration
	logic [15:0] peak_q, appear_q, disappear_q;
	logic [31:0] fo_start_q;
	logic        loop_q;
	logic [1:0]  notify_q;

	// envelope state
	logic [1:0]  phase_q;
	logic [16:0] timer_q;
	logic [15:0] gain_q;
	logic        event_q;

	// latched item
	logic        mode_q, stopped_q;
	logic [15:0] elapsed_q;
	logic [31:0] pos_q;
	logic [1:0]  newph_q;

	// divider
	logic [15:0] rem_q, quo_q;
	logic [afe_pkg::CNT_W-1:0] cnt_q;

	// output register
	logic        out_valid_q;
	logic [23:0] out_q;

	afe_pkg::state_t state_q, state_nxt;

	logic        accept, out_free, out_load, div_last;
	logic [15:0] fade_len;
	logic [16:0] t_sum, t_new;
	logic        t_end;

	logic [1:0]  ev_phase;
	logic [16:0] ev_timer;
	logic [15:0] ev_gain;
	logic        ev_gain_we, ev_event, ev_mul;

	logic [31:0] prod;
	logic [16:0] trial;
	logic        ge;
	logic [15:0] rem_nxt, quo_nxt;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign div_last = cnt_q == afe_pkg::CNT_W'(afe_pkg::DIV_STEPS - 1);

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q      <= 16'd65535;
			appear_q    <= 16'd1000;
			disappear_q <= 16'd1000;
			fo_start_q  <= 32'd0;
			loop_q      <= 1'b0;
			notify_q    <= 2'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				afe_pkg::REG_PEAK:      peak_q      <= cfg_data[15:0];
				afe_pkg::REG_APPEAR:    appear_q    <= cfg_data[15:0];
				afe_pkg::REG_DISAPPEAR: disappear_q <= cfg_data[15:0];
				afe_pkg::REG_FO_START:  fo_start_q  <= cfg_data;
				afe_pkg::REG_LOOP:      loop_q      <= cfg_data[0];
				afe_pkg::REG_NOTIFY:    notify_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			afe_pkg::ST_IDLE: if (s_axis_tvalid) state_nxt = afe_pkg::ST_EVAL;
			afe_pkg::ST_EVAL: state_nxt = ev_mul ? afe_pkg::ST_MUL : afe_pkg::ST_FIN;
			afe_pkg::ST_MUL:  state_nxt = afe_pkg::ST_DIV;
			afe_pkg::ST_DIV:  if (div_last) state_nxt = afe_pkg::ST_FIN;
			afe_pkg::ST_FIN:  if (out_free) state_nxt = afe_pkg::ST_IDLE;
			default:          state_nxt = afe_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			afe_pkg::ST_IDLE: s_axis_tready = 1'b1;
			afe_pkg::ST_FIN:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= afe_pkg::ST_IDLE;
		else         state_q <= state_nxt;
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= s_axis_tuser;
			elapsed_q <= s_axis_tdata[15:0];
			pos_q     <= s_axis_tdata[47:16];
			stopped_q <= s_axis_tdata[48];
			newph_q   <= s_axis_tdata[50:49];
		end
	end

	// advance the fade timer
	assign fade_len = (phase_q == afe_pkg::PH_FADE_IN) ? appear_q : disappear_q;
	assign t_sum    = timer_q + {1'b0, elapsed_q};
	assign t_new    = (timer_q < {1'b0, fade_len}) ? t_sum : timer_q;
	assign t_end    = t_new >= {1'b0, fade_len};

	// evaluate one step of the envelope
	always_comb begin
		ev_phase   = phase_q;
		ev_timer   = timer_q;
		ev_gain    = gain_q;
		ev_gain_we = 1'b0;
		ev_event   = 1'b0;
		ev_mul     = 1'b0;
		if (mode_q == afe_pkg::MODE_FORCE) begin
			if (phase_q != newph_q) begin
				ev_phase = newph_q;
				ev_timer = 17'd0;
				ev_event = (newph_q == afe_pkg::PH_FADE_OUT)
					&& (notify_q == afe_pkg::NP_FADE_OUT_START);
			end
		end else begin
			case (phase_q)
				afe_pkg::PH_FADE_IN, afe_pkg::PH_FADE_OUT: begin
					if (t_end) begin
						ev_timer   = 17'd0;
						ev_gain_we = 1'b1;
						if (phase_q == afe_pkg::PH_FADE_IN) begin
							ev_gain  = peak_q;
							ev_phase = afe_pkg::PH_HOLD;
							ev_event = notify_q == afe_pkg::NP_FADE_IN_END;
						end else begin
							ev_gain  = 16'd0;
							ev_phase = afe_pkg::PH_DONE;
							ev_event = notify_q == afe_pkg::NP_DONE;
						end
					end else begin
						ev_timer = t_new;
						ev_mul   = 1'b1;
					end
				end
				afe_pkg::PH_HOLD: begin
					if (!loop_q && (pos_q >= fo_start_q || stopped_q)) begin
						ev_phase = afe_pkg::PH_FADE_OUT;
						ev_event = notify_q == afe_pkg::NP_FADE_OUT_START;
					end
				end
				default: ;
			endcase
		end
	end

	// shared multiply and restoring divide step
	assign prod    = 32'(peak_q) * 32'(timer_q[15:0]);
	assign trial   = {rem_q, quo_q[15]};
	assign ge      = trial >= {1'b0, fade_len};
	assign rem_nxt = ge ? 16'(trial - {1'b0, fade_len}) : trial[15:0];
	assign quo_nxt = {quo_q[14:0], ge};

	always_ff @(posedge clk) begin
		if (state_q == afe_pkg::ST_MUL) begin
			rem_q <= prod[31:16];
			quo_q <= prod[15:0];
		end else if (state_q == afe_pkg::ST_DIV) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (state_q == afe_pkg::ST_MUL) cnt_q <= '0;
		else if (state_q == afe_pkg::ST_DIV) cnt_q <= cnt_q + 1'b1;
	end

	// update envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= afe_pkg::PH_FADE_IN;
			timer_q <= 17'd0;
			gain_q  <= 16'd0;
			event_q <= 1'b0;
		end else if (state_q == afe_pkg::ST_EVAL) begin
			phase_q <= ev_phase;
			timer_q <= ev_timer;
			event_q <= ev_event;
			if (ev_gain_we) gain_q <= ev_gain;
		end else if (state_q == afe_pkg::ST_DIV && div_last) begin
			gain_q <= (phase_q == afe_pkg::PH_FADE_IN) ? quo_nxt : peak_q - quo_nxt;
		end
	end

	// hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= {4'd0, phase_q == afe_pkg::PH_DONE, event_q, phase_q, gain_q};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	`AFE_ASSERT_NEXT(a_accept_eval, accept, state_q == afe_pkg::ST_EVAL)
	`AFE_ASSERT_NOW(a_div_rem_below_len, state_q == afe_pkg::ST_DIV, rem_q < fade_len)
	`AFE_ASSERT_NOW(a_mul_timer_narrow, state_q == afe_pkg::ST_MUL, timer_q < {1'b0, fade_len})
	`AFE_ASSERT_NOW(a_remove_matches_done, m_axis_tvalid,
		m_axis_tdata[19] == (m_axis_tdata[17:16] == afe_pkg::PH_DONE))

endmodule

// ===== tb/audio_fade_envelope_tb.sv =====
`timescale 1ns / 100ps

module audio_fade_envelope_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 25;
	localparam int MAX_PRINTED    = 40;

	typedef struct packed {
		logic [15:0] volume;
		logic [1:0]  phase;
		logic        rel_evt;
		logic        remove;
	} envelope_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [55:0]          s_axis_tdata = '0;   // elapsed[15:0], play_position[47:16],
	                                           // player_stopped[48], new_phase[50:49]
	logic                 s_axis_tuser = 1'b0; // mode
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;        // volume[15:0], phase[17:16],
	                                           // release_event[18], remove_request[19]
	logic                 cfg_we = 1'b0;
	logic [afe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	// register copies and envelope state of the expected behavior
	logic [15:0] cfg_peak;
	logic [15:0] cfg_appear;
	logic [15:0] cfg_disappear;
	logic [31:0] cfg_fo_start;
	logic        cfg_loop;
	logic [1:0]  cfg_notify;
	logic [1:0]  env_phase;
	logic [16:0] env_timer;
	logic [15:0] env_gain;

	envelope_out_t envelope_out_q[$];
	int mismatches = 0;
	int items_sent = 0;
	int wd_idle = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic [31:0] pos_cursor = '0;

	audio_fade_envelope u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// stall the result side at random
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		if (mismatches < MAX_PRINTED)
			$display("MISMATCH %s: got %0d, want %0d (item count %0d)", what, got_v, want_v,
				items_sent);
		mismatches++;
	endtask

	// peak * t / len, floored; caller keeps t below len
	function automatic logic [15:0] fade_fraction(input logic [16:0] t, input logic [15:0] len);
		logic [63:0] prod;
		prod = 64'(cfg_peak) * 64'(t);
		return 16'(prod / 64'(len));
	endfunction

	// advance the expected envelope by one accepted transaction
	task automatic advance_envelope(input logic mode, input logic [15:0] elapsed,
			input logic [31:0] pos, input logic stopped, input logic [1:0] new_phase);
		envelope_out_t res;
		logic rel_evt;
		rel_evt = 1'b0;
		if (mode == afe_pkg::MODE_FORCE) begin
			if (env_phase != new_phase) begin
				env_timer = '0;
				env_phase = new_phase;
				if (new_phase == afe_pkg::PH_FADE_OUT
						&& cfg_notify == afe_pkg::NP_FADE_OUT_START)
					rel_evt = 1'b1;
			end
		end else begin
			case (env_phase)
				afe_pkg::PH_FADE_IN: begin
					if (env_timer < {1'b0, cfg_appear})
						env_timer = env_timer + {1'b0, elapsed};
					if (env_timer >= {1'b0, cfg_appear}) begin
						env_gain  = cfg_peak;
						env_timer = '0;
						env_phase = afe_pkg::PH_HOLD;
						if (cfg_notify == afe_pkg::NP_FADE_IN_END)
							rel_evt = 1'b1;
					end else begin
						env_gain = fade_fraction(env_timer, cfg_appear);
					end
				end
				afe_pkg::PH_HOLD: begin
					if (!cfg_loop && (pos >= cfg_fo_start || stopped)) begin
						env_phase = afe_pkg::PH_FADE_OUT;
						if (cfg_notify == afe_pkg::NP_FADE_OUT_START)
							rel_evt = 1'b1;
					end
				end
				afe_pkg::PH_FADE_OUT: begin
					if (env_timer < {1'b0, cfg_disappear})
						env_timer = env_timer + {1'b0, elapsed};
					if (env_timer >= {1'b0, cfg_disappear}) begin
						env_gain  = '0;
						env_timer = '0;
						env_phase = afe_pkg::PH_DONE;
						if (cfg_notify == afe_pkg::NP_DONE)
							rel_evt = 1'b1;
					end else begin
						env_gain = cfg_peak - fade_fraction(env_timer, cfg_disappear);
					end
				end
				default: ;
			endcase
		end
		res.volume  = env_gain;
		res.phase   = env_phase;
		res.rel_evt = rel_evt;
		res.remove  = (env_phase == afe_pkg::PH_DONE);
		envelope_out_q.push_back(res);
	endtask

	// check each result transaction and count cycles with no transaction
	always @(posedge clk) begin
		envelope_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (envelope_out_q.size() == 0) begin
				report_mismatch("result with nothing pending", m_axis_tdata, 0);
			end else begin
				want = envelope_out_q.pop_front();
				if (m_axis_tdata[15:0] !== want.volume)
					report_mismatch("volume", m_axis_tdata[15:0], want.volume);
				if (m_axis_tdata[17:16] !== want.phase)
					report_mismatch("phase", m_axis_tdata[17:16], want.phase);
				if (m_axis_tdata[18] !== want.rel_evt)
					report_mismatch("release_event", m_axis_tdata[18], want.rel_evt);
				if (m_axis_tdata[19] !== want.remove)
					report_mismatch("remove_request", m_axis_tdata[19], want.remove);
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			wd_idle <= 0;
		else
			wd_idle <= wd_idle + 1;
	end

	// end the run if no transaction moves for too long
	initial begin
		while (wd_idle < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("audio_fade_envelope verification failed");
		$finish;
	end

	task automatic send_item(input logic mode, input logic [15:0] elapsed,
			input logic [31:0] pos, input logic stopped, input logic [1:0] new_phase);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {5'd0, new_phase, stopped, pos, elapsed};
		do @(posedge clk); while (!s_axis_tready);
		advance_envelope(mode, elapsed, pos, stopped, new_phase);
		items_sent++;
	endtask

	// tick with random filler in the unused phase field
	task automatic send_tick(input logic [15:0] elapsed, input logic [31:0] pos,
			input logic stopped);
		send_item(afe_pkg::MODE_TICK, elapsed, pos, stopped, 2'($urandom()));
	endtask

	// force with random filler in the fields a force ignores
	task automatic send_force(input logic [1:0] new_phase);
		send_item(afe_pkg::MODE_FORCE, 16'($urandom()), $urandom(), 1'($urandom()),
			new_phase);
	endtask

	// drop valid and wait until every pending result has come back
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (envelope_out_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// one register write; the copies keep only the bits each register stores
	task automatic write_reg(input logic [afe_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			afe_pkg::REG_PEAK:      cfg_peak      = data[15:0];
			afe_pkg::REG_APPEAR:    cfg_appear    = data[15:0];
			afe_pkg::REG_DISAPPEAR: cfg_disappear = data[15:0];
			afe_pkg::REG_FO_START:  cfg_fo_start  = data;
			afe_pkg::REG_LOOP:      cfg_loop      = data[0];
			afe_pkg::REG_NOTIFY:    cfg_notify    = data[1:0];
			default: ;
		endcase
	endtask

	function automatic logic [15:0] random_length();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return 16'd0;
		if (pick == 1) return 16'hFFFF;
		if (pick == 2) return 16'd1;
		return 16'($urandom_range(1, 3000));
	endfunction

	task automatic pick_random_config();
		int pick;
		logic [15:0] peak;
		logic [31:0] fo_start;
		pick = $urandom_range(9);
		peak = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom());
		pick = $urandom_range(3);
		fo_start = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom() :
			32'($urandom_range(0, 3000));
		write_reg(afe_pkg::REG_PEAK, {16'($urandom()), peak});
		write_reg(afe_pkg::REG_APPEAR, {16'($urandom()), random_length()});
		write_reg(afe_pkg::REG_DISAPPEAR, {16'($urandom()), random_length()});
		write_reg(afe_pkg::REG_FO_START, fo_start);
		write_reg(afe_pkg::REG_LOOP, {31'($urandom()), ($urandom_range(4) == 0)});
		write_reg(afe_pkg::REG_NOTIFY, {30'($urandom()), 2'($urandom())});
		// unused indexes must not disturb anything
		if ($urandom_range(4) == 0)
			write_reg(afe_pkg::CFG_IDX_W'($urandom_range(6, 7)), $urandom());
		pos_cursor = $urandom_range(0, 2000);
	endtask

	// default registers: full fade-in, hold exit, fade-out, done
	task automatic test_default_envelope();
		send_tick(16'd0, 32'd0, 1'b0);
		send_tick(16'd500, 32'd0, 1'b0);
		send_tick(16'hFFFF, 32'd0, 1'b0);
		send_tick(16'd0, 32'd0, 1'b0);
		send_tick(16'd1, 32'd1, 1'b0);
		send_tick(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_tick(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
	endtask

	// forces to the same and to other phases, event on forced fade-out
	task automatic test_forced_phases();
		send_force(afe_pkg::PH_DONE);
		send_force(afe_pkg::PH_FADE_IN);
		send_force(afe_pkg::PH_HOLD);
		wait_idle();
		write_reg(afe_pkg::REG_NOTIFY, {30'd0, afe_pkg::NP_FADE_OUT_START});
		send_force(afe_pkg::PH_FADE_OUT);
		send_force(afe_pkg::PH_FADE_OUT);
		send_force(afe_pkg::PH_DONE);
	endtask

	// zero fade lengths, looping hold, exit only at the last position
	task automatic test_zero_length_and_loop();
		wait_idle();
		write_reg(afe_pkg::REG_PEAK, 32'hFFFF_8001);
		write_reg(afe_pkg::REG_APPEAR, 32'd0);
		write_reg(afe_pkg::REG_DISAPPEAR, 32'd0);
		write_reg(afe_pkg::REG_FO_START, 32'hFFFF_FFFF);
		write_reg(afe_pkg::REG_LOOP, 32'd1);
		write_reg(afe_pkg::REG_NOTIFY, {30'd0, afe_pkg::NP_DONE});
		send_force(afe_pkg::PH_FADE_IN);
		send_tick(16'd0, 32'd0, 1'b0);
		send_tick(16'd0, 32'hFFFF_FFFF, 1'b1);
		wait_idle();
		write_reg(afe_pkg::REG_LOOP, 32'd0);
		send_tick(16'd0, 32'hFFFF_FFFE, 1'b0);
		send_tick(16'd0, 32'hFFFF_FFFF, 1'b0);
		send_tick(16'd0, 32'd0, 1'b0);
	endtask

	// fade length lowered below a running timer ends the fade
	task automatic test_timer_past_length();
		wait_idle();
		write_reg(afe_pkg::REG_APPEAR, 32'd1000);
		write_reg(afe_pkg::REG_DISAPPEAR, 32'd1000);
		write_reg(afe_pkg::REG_NOTIFY, {30'd0, afe_pkg::NP_FADE_IN_END});
		send_force(afe_pkg::PH_FADE_IN);
		send_tick(16'd600, 32'd0, 1'b0);
		wait_idle();
		write_reg(afe_pkg::REG_APPEAR, 32'd300);
		send_tick(16'd0, 32'd0, 1'b0);
		send_force(afe_pkg::PH_FADE_OUT);
		send_tick(16'd700, 32'd0, 1'b0);
		wait_idle();
		write_reg(afe_pkg::REG_DISAPPEAR, 32'd200);
		send_tick(16'd0, 32'd0, 1'b0);
	endtask

	// episodes of random registers and mostly well-formed tick runs
	task automatic test_random_envelopes(input int n_items, input int tx_pct, input int rx_pct);
		int stop_at;
		int run_len;
		int pick;
		logic [15:0] len;
		logic [15:0] elapsed;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			wait_idle();
			pick_random_config();
			if ($urandom_range(9) < 7)
				send_force(afe_pkg::PH_FADE_IN);
			run_len = $urandom_range(8, 40);
			for (int k = 0; k < run_len; k++) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					send_force(2'($urandom()));
				end else if (pick < 12) begin
					send_tick(16'($urandom()), $urandom(), 1'($urandom()));
				end else begin
					len = (env_phase == afe_pkg::PH_FADE_OUT) ? cfg_disappear : cfg_appear;
					elapsed = 16'($urandom_range(0, int'(len) / 3 + 1));
					pos_cursor = pos_cursor + elapsed;
					send_tick(elapsed, pos_cursor, ($urandom_range(19) == 0));
				end
			end
		end
	endtask

	initial begin
		cfg_peak      = 16'hFFFF;
		cfg_appear    = 16'd1000;
		cfg_disappear = 16'd1000;
		cfg_fo_start  = 32'd0;
		cfg_loop      = 1'b0;
		cfg_notify    = afe_pkg::NP_FADE_IN_END;
		env_phase     = afe_pkg::PH_FADE_IN;
		env_timer     = '0;
		env_gain      = '0;
		tx_idle_pct   = 6;
		rx_stall_pct  = 80;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_envelope();
		test_forced_phases();
		test_zero_length_and_loop();
		test_timer_past_length();
		test_random_envelopes(300, 6, 80);
		test_random_envelopes(300, 80, 6);
		test_random_envelopes(300, 0, 0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("audio_fade_envelope verification clean");
		else
			$display("audio_fade_envelope verification failed");
		$finish;
	end

endmodule
